// ===== rtl/core/smlf_pkg.sv =====
package smlf_pkg;

    localparam int OFS_W = 32;
    localparam int LEN_W = 7;

    localparam logic       OP_DATA      = 1'b0;
    localparam logic       OP_END       = 1'b1;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [OFS_W-1:0] best_offset;
        logic [LEN_W-1:0] best_len;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic take_byte;
        logic take_end;
    } t_cmd;

    // running comparison of the open line against the stored best
    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } t_cmp;

endpackage

// ===== rtl/core/smlf_ctrl.sv =====
module smlf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output smlf_pkg::t_cmd o_cmd
);
    import smlf_pkg::*;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_HOLD = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept          = i_in_valid && (r_state == S_RUN);
    assign o_cmd.take_byte = accept && (i_in_op == OP_DATA);
    assign o_cmd.take_end  = accept && (i_in_op == OP_END);
    assign o_in_stall      = (r_state == S_HOLD);
    assign o_out_valid     = (r_state == S_HOLD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (o_cmd.take_end) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!i_out_stall) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_rose_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.take_end))
        else $error("result raised without an end transfer");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_end |=> o_out_valid)
        else $error("end transfer produced no result");

endmodule

// ===== rtl/core/smlf_dp.sv =====
module smlf_dp #(
    parameter int MAX_LINE = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smlf_pkg::t_cmd      i_cmd,
    input  smlf_pkg::t_in_item  i_item,
    output smlf_pkg::t_out_item o_item
);
    import smlf_pkg::*;

    localparam int CW = $clog2(MAX_LINE);
    localparam int AW = CW + 1;
    localparam logic [CW-1:0] LAST = CW'(MAX_LINE - 1);

    // two line banks: one holds the open line, the other the best line
    logic [7:0]       r_mem [2**AW];
    logic [7:0]       r_rd;
    logic             r_bank, n_bank;
    logic [CW-1:0]    r_cur_count, n_cur_count;
    logic [CW-1:0]    r_best_count, n_best_count;
    logic [OFS_W-1:0] r_cur_begin, n_cur_begin;
    logic [OFS_W-1:0] r_best_begin, n_best_begin;
    logic [OFS_W-1:0] r_pos, n_pos;
    t_cmp             r_cmp, n_cmp;
    t_out_item        r_out, n_out;

    logic             is_nl;
    logic             append;
    logic             in_best;
    logic             smaller;
    logic             replace;
    logic [CW-1:0]    fin_count;
    logic [OFS_W-1:0] fin_begin;

    assign is_nl   = (i_item.data_byte == NEWLINE_BYTE);
    assign append  = !is_nl && (r_cur_count != LAST);
    assign in_best = (r_cur_count < r_best_count);
    assign smaller = (r_cmp == CMP_LT) || ((r_cmp == CMP_EQ) && in_best);
    assign replace = (r_best_count == '0) || smaller;

    assign fin_count = ((r_cur_count != '0) && replace) ? r_cur_count : r_best_count;
    assign fin_begin = ((r_cur_count != '0) && replace) ? r_cur_begin : r_best_begin;

    assign o_item = r_out;

    always_comb begin
        n_bank       = r_bank;
        n_cur_count  = r_cur_count;
        n_best_count = r_best_count;
        n_cur_begin  = r_cur_begin;
        n_best_begin = r_best_begin;
        n_pos        = r_pos;
        n_cmp        = r_cmp;
        n_out        = r_out;
        if (i_cmd.take_end) begin
            n_out.best_offset = (fin_count == '0) ? '0 : fin_begin;
            n_out.best_len    = LEN_W'(fin_count);
            n_cur_count       = '0;
            n_best_count      = '0;
            n_cur_begin       = '0;
            n_best_begin      = '0;
            n_pos             = '0;
            n_cmp             = CMP_EQ;
        end else if (i_cmd.take_byte) begin
            n_pos = r_pos + OFS_W'(1);
            if (append) begin
                n_cur_count = r_cur_count + CW'(1);
                if (r_cur_count == '0) begin
                    n_cur_begin = r_pos;
                end
                if ((r_cmp == CMP_EQ) && in_best) begin
                    if (i_item.data_byte < r_rd) begin
                        n_cmp = CMP_LT;
                    end else if (i_item.data_byte > r_rd) begin
                        n_cmp = CMP_GT;
                    end
                end
            end else begin
                // close the line; swap banks instead of copying
                if (replace) begin
                    n_bank       = ~r_bank;
                    n_best_count = r_cur_count;
                    n_best_begin = r_cur_begin;
                end
                n_cur_count = '0;
                n_cmp       = CMP_EQ;
            end
        end
    end

    // prefetch the best-line byte at the next write position
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && append) begin
            r_mem[{r_bank, r_cur_count}] <= i_item.data_byte;
        end
        r_rd  <= r_mem[{~n_bank, n_cur_count}];
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= 1'b0;
            r_cur_count  <= '0;
            r_best_count <= '0;
            r_cur_begin  <= '0;
            r_best_begin <= '0;
            r_pos        <= '0;
            r_cmp        <= CMP_EQ;
        end else begin
            r_bank       <= n_bank;
            r_cur_count  <= n_cur_count;
            r_best_count <= n_best_count;
            r_cur_begin  <= n_cur_begin;
            r_best_begin <= n_best_begin;
            r_pos        <= n_pos;
            r_cmp        <= n_cmp;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_count <= LAST) && (r_best_count <= LAST))
        else $error("line count beyond limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_end |=> ((r_cur_count == '0) && (r_best_count == '0) && (r_pos == '0)))
        else $error("state not cleared after end");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_byte && append) |=> (r_cur_count == $past(r_cur_count) + CW'(1)))
        else $error("append did not advance count");

endmodule

// ===== rtl/core/streaming_min_line_finder.sv =====
// Streaming minimum-line finder.
// Input channel (i_in_valid / o_in_stall / i_in_item): one transfer per byte of
// newline-separated text (op = data), or an end marker (op = end). Bytes are
// numbered from offset 0; each closed line is compared byte by byte, unsigned,
// against the best line so far, and a proper prefix counts as smaller.
// Output channel (o_out_valid / i_out_stall / o_out_item): one transfer per end
// marker, carrying the first-byte offset and length of the smallest line
// (offset 0 and length 0 when there is none).
// Throughput: one data byte per cycle while no result waits. The comparison
// runs as bytes arrive, with the best-line byte prefetched from a two-bank
// line store; closing a line only swaps banks.
// The result shows in the cycle after the end transfer. While the result
// waits, input is stalled, so the block holds one result at a time, and an
// end item blocks input until the receiver takes its result.
// A line reaching MAX_LINE-1 bytes closes at the next non-newline byte, which
// is dropped but still counts toward offsets.
// Reset (synchronous, active low) and every end transfer clear counts,
// offsets and the running comparison; the line store needs no clearing.
module streaming_min_line_finder #(
    parameter int MAX_LINE = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  smlf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smlf_pkg::t_out_item o_out_item
);
    import smlf_pkg::*;

    t_cmd cmd;

    // accept transfers and sequence the result handshake
    smlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_item.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // line store, running comparison and result register
    smlf_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

endmodule

// ===== dv/tb_streaming_min_line_finder.sv =====
`timescale 1ns / 100ps

module tb_streaming_min_line_finder;

    import smlf_pkg::*;

    localparam int          MAX_LINE    = 128;
    localparam int          CLK_HALF    = 2;
    localparam int          RST_CYCLES  = 9;
    localparam int          RAND_ITEMS  = 1250;
    localparam int          RAND_ENDS   = 24;
    localparam int          DRAIN_WAIT  = 8;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Clock, reset and the DUT inputs, all at known values from time zero.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    streaming_min_line_finder #(
        .MAX_LINE(MAX_LINE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Minimum-line predictor: its own copy of the open line, the best line
    // so far and the running byte offset.
    // ------------------------------------------------------------------
    logic [7:0]  open_line [MAX_LINE];
    logic [7:0]  best_line [MAX_LINE];
    int unsigned open_len;
    int unsigned best_len;
    logic [31:0] open_start;
    logic [31:0] best_start;
    logic [31:0] next_ofs;

    // Results predicted but not yet seen on the output channel, oldest first.
    t_out_item   pending_minimums [$];

    int unsigned error_cnt;
    int unsigned items_sent;
    int unsigned ends_sent;
    int unsigned cycle_cnt;
    bit          calm_phase;

    // Stall generator state for the output channel.
    int unsigned stall_hold;
    logic        stall_now;
    int unsigned stall_pick;

    function automatic void clear_min_line_state();
        open_len   = 0;
        best_len   = 0;
        open_start = '0;
        best_start = '0;
        next_ofs   = '0;
    endfunction

    // Unsigned byte-wise compare; a proper prefix is the smaller line.
    function automatic bit open_line_smaller();
        int unsigned n;
        n = (open_len < best_len) ? open_len : best_len;
        for (int unsigned i = 0; i < n; i++) begin
            if (open_line[i] < best_line[i]) return 1'b1;
            if (open_line[i] > best_line[i]) return 1'b0;
        end
        return open_len < best_len;
    endfunction

    // Close the open line: an empty best counts as none and always loses.
    function automatic void close_open_line();
        if (best_len == 0 || open_line_smaller()) begin
            for (int unsigned i = 0; i < open_len; i++) begin
                best_line[i] = open_line[i];
            end
            best_len   = open_len;
            best_start = open_start;
        end
        open_len = 0;
    endfunction

    function automatic void update_min_line(t_in_item it);
        t_out_item res;
        if (it.op == OP_END) begin
            // End marker: close any open line, report, start over.
            if (open_len > 0) close_open_line();
            res.best_offset = (best_len == 0) ? '0 : best_start;
            res.best_len    = best_len[LEN_W-1:0];
            pending_minimums.push_back(res);
            clear_min_line_state();
        end else begin
            // A newline, or any byte once the line is full, closes the line.
            // The byte that overflows a full line is dropped but still
            // advances the offset.
            if (it.data_byte != NEWLINE_BYTE && open_len < MAX_LINE - 1) begin
                if (open_len == 0) open_start = next_ofs;
                open_line[open_len] = it.data_byte;
                open_len++;
            end else begin
                close_open_line();
            end
            next_ofs = next_ofs + 32'd1;
        end
    endfunction

    // Track every input transfer. Sample at the edge, before any NBA lands.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            update_min_line(i_in_item);
        end
    end

    // Check every output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_minimums.size() == 0) begin
                $error("unexpected result: best_offset=%0d best_len=%0d",
                       o_out_item.best_offset, o_out_item.best_len);
                error_cnt++;
            end else begin
                t_out_item exp_res;
                exp_res = pending_minimums.pop_front();
                if (o_out_item.best_offset !== exp_res.best_offset) begin
                    $error("best_offset: expected %0d, got %0d",
                           exp_res.best_offset, o_out_item.best_offset);
                    error_cnt++;
                end
                if (o_out_item.best_len !== exp_res.best_len) begin
                    $error("best_len: expected %0d, got %0d",
                           exp_res.best_len, o_out_item.best_len);
                    error_cnt++;
                end
            end
        end
    end

    // Output stall: runs of free cycles, short stalls, now and then a long
    // one. Calm phases hold stall low throughout.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (calm_phase || stall_pick < 55) begin
                stall_now  = 1'b0;
                stall_hold = $urandom_range(1, 8);
            end else if (stall_pick < 92) begin
                stall_now  = 1'b1;
                stall_hold = $urandom_range(1, 3);
            end else begin
                stall_now  = 1'b1;
                stall_hold = $urandom_range(10, 40);
            end
        end
        stall_hold--;
        i_out_stall <= stall_now;
    end

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_streaming_min_line_finder: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Idle gap before a transfer: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Send one item: idle for a random gap, then hold valid and the payload
    // until the transfer happens. Each path issues one NBA per signal per edge.
    task automatic send_item(input logic op, input logic [7:0] data_byte);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_item.op        <= op;
        i_in_item.data_byte <= data_byte;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (op == OP_END) ends_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(OP_DATA, s[i]);
        end
    endtask

    // End marker with nothing before it, twice in a row; data byte ignored.
    task automatic test_end_markers();
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'hFF);
    endtask

    // Byte extremes, proper prefixes, a tie, and an unterminated last line.
    task automatic test_order_and_prefix();
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, NEWLINE_BYTE);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h01);
        send_item(OP_DATA, NEWLINE_BYTE);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, NEWLINE_BYTE);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'hA5);
        send_text("ba\nb\nab");
        send_item(OP_END, 8'h5A);
    endtask

    // Empty lines knock the best back to none; a lone newline before end
    // leaves no best at all.
    task automatic test_empty_lines();
        send_text("\nz\nm\n\nq\n");
        send_item(OP_END, 8'h00);
        send_text("k\n\n");
        send_item(OP_END, 8'h00);
    endtask

    // Lines that fill the store: the next non-newline byte closes the line
    // and is dropped; a newline right at the limit closes it normally.
    task automatic test_long_lines();
        for (int i = 0; i < MAX_LINE - 1; i++) send_item(OP_DATA, "b");
        send_text("xc\n");
        for (int i = 0; i < MAX_LINE - 1; i++) send_item(OP_DATA, "a");
        send_item(OP_DATA, NEWLINE_BYTE);
        send_item(OP_END, 8'h00);
        for (int i = 0; i < MAX_LINE + 3; i++) send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'h00);
    endtask

    // Random documents: mostly well-formed line sets from a narrow alphabet
    // (ties and shared prefixes), some with full-range bytes, a few long
    // lines, and some raw noise with stray end markers.
    task automatic test_random_documents();
        int unsigned doc_idx;
        int unsigned n_lines;
        int unsigned line_len;
        int unsigned r;
        bit          narrow;
        logic [7:0]  base;
        doc_idx = 0;
        while (items_sent < RAND_ITEMS || ends_sent < RAND_ENDS) begin
            if (doc_idx % 8 == 0) calm_phase = ($urandom_range(0, 3) == 0);
            doc_idx++;
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any op, any byte.
                repeat ($urandom_range(1, 20)) begin
                    send_item(($urandom_range(0, 4) == 0) ? OP_END : OP_DATA,
                              8'($urandom_range(0, 255)));
                end
                continue;
            end
            narrow  = ($urandom_range(0, 9) < 7);
            base    = 8'($urandom_range(0, 253));
            n_lines = $urandom_range(0, 6);
            for (int unsigned ln = 0; ln < n_lines; ln++) begin
                r = $urandom_range(0, 99);
                if (r < 80)      line_len = $urandom_range(0, 10);
                else if (r < 95) line_len = $urandom_range(11, 40);
                else             line_len = $urandom_range(MAX_LINE - 8, MAX_LINE + 7);
                repeat (line_len) begin
                    if (narrow) send_item(OP_DATA, base + 8'($urandom_range(0, 2)));
                    else        send_item(OP_DATA, 8'($urandom_range(0, 255)));
                end
                // Leave the last line open at times; the end marker closes it.
                if (ln + 1 < n_lines || $urandom_range(0, 1) == 0) begin
                    send_item(OP_DATA, NEWLINE_BYTE);
                end
            end
            send_item(OP_END, 8'($urandom_range(0, 255)));
        end
        calm_phase = 1'b0;
    endtask

    initial begin
        error_cnt  = 0;
        items_sent = 0;
        ends_sent  = 0;
        cycle_cnt  = 0;
        calm_phase = 1'b0;
        stall_hold = 0;
        clear_min_line_state();

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_end_markers();
        test_order_and_prefix();
        test_empty_lines();
        test_long_lines();
        test_random_documents();

        // Drop valid, drain outstanding results, then allow for latency.
        i_in_valid <= 1'b0;
        while (pending_minimums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("tb_streaming_min_line_finder: done, clean");
        end else begin
            $display("tb_streaming_min_line_finder: done, errors");
        end
        $finish;
    end

endmodule
